[rtl/csv_field_parser_assert.svh]
// ----------------------------------------------------------------------------
// csv_field_parser_assert.svh
// Assertion macros used by the CSV field parser RTL.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_PARSER_ASSERT_SVH
`define CSV_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFP_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFP_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and character codes for the CSV field parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfp_pkg;

	localparam int CHAR_W = 16;

	localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
	localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;

	// Field and line tracking flags
	typedef struct packed {
		logic started;   // non-blank character of the field seen
		logic in_q;      // inside the quoted part
		logic q_pend;    // quote seen inside quotes, next unit decides
		logic was_q;     // field was opened by a quote
		logic skip_lf;   // line ended on CR, drop one LF
	} state_t;

	// One result item
	typedef struct packed {
		logic              has_char;
		logic [CHAR_W-1:0] char_out;
		logic              field_end;
		logic              line_end;
		logic              field_quoted;
		logic              is_last;
	} result_t;

endpackage

[rtl/cfp_text_if.sv]
// ----------------------------------------------------------------------------
// cfp_text_if
// Input channel: one UTF-16 code unit and the stream end flag per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfp_text_if import cfp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              stream_end;

	modport source (output valid, output char_in, output stream_end, input ready);
	modport sink   (input valid, input char_in, input stream_end, output ready);
endinterface

[rtl/cfp_token_if.sv]
// ----------------------------------------------------------------------------
// cfp_token_if
// Output channel: one payload character or field end event per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfp_token_if import cfp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              has_char;
	logic [CHAR_W-1:0] char_out;
	logic              field_end;
	logic              line_end;
	logic              field_quoted;
	logic              is_last;

	modport source (output valid, output has_char, output char_out, output field_end,
		output line_end, output field_quoted, output is_last, input ready);
	modport sink   (input valid, input has_char, input char_out, input field_end,
		input line_end, input field_quoted, input is_last, output ready);
endinterface

[rtl/csv_field_parser.sv]
// ----------------------------------------------------------------------------
// csv_field_parser
// Streaming CSV field splitter: one UTF-16 code unit in per request, payload
// characters and field/line end events out.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Payload                                              | Handshake
// ---------+-----+------------------------------------------------------+------------
// text     | in  | char_in[15:0], stream_end                            | valid/ready
// token    | out | has_char, char_out[15:0], field_end, line_end,       | valid/ready
//          |     | field_quoted, is_last                                |
// delim_*  | in  | delim_wdata[15:0], written when delim_we is high     | none
//
// A taken request sits in the input register, is decoded and loaded into the
// output register once that is free, and its first result is then on the port.
// One request per cycle holds while each yields at most one result and the token side
// is ready; a character plus an end event holds the output register until both go.
// arst_n clears all flags, s1_v and the output count and sets the delimiter to comma.
// A stalled token side holds its result; a full, stuck input register drops text ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_parser import cfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cfp_text_if.sink          text,
	cfp_token_if.source       token,
	input  logic              delim_we,
	input  logic [CHAR_W-1:0] delim_wdata
);

	`include "csv_field_parser_assert.svh"

	// Delimiter register
	logic [CHAR_W-1:0] delim_q;

	// Input register
	logic              s1_v;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;

	// Parser flags
	state_t st_q;
	state_t st_next;

	// Decoded results of the item in the input register
	logic [1:0] res_cnt;
	result_t    res0;
	result_t    res1;

	// Output register: head is on the port, tail waits behind it
	logic [1:0] out_cnt_q;
	result_t    out_head_q;
	result_t    out_tail_q;

	logic in_take;
	logic pop;
	logic out_free;
	logic advance;

	// Output register drains to empty this cycle, or already is
	assign pop      = token.valid && token.ready;
	assign out_free = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && token.ready);
	// Move the registered item through the decoder into the output register
	assign advance  = s1_v && out_free;
	assign in_take  = text.valid && text.ready;

	assign text.ready = !s1_v || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= CH_COMMA;
		end else if (delim_we) begin
			delim_q <= delim_wdata;
		end
	end

	// Input register: load on a taken request, drop once decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_take) begin
			s1_v <= 1'b1;
		end else if (advance) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= text.char_in;
			end_s1  <= text.stream_end;
		end
	end

	cfp_step u_step (
		.char_in    (char_s1),
		.stream_end (end_s1),
		.delimiter  (delim_q),
		.st         (st_q),
		.st_next    (st_next),
		.res_cnt    (res_cnt),
		.res0       (res0),
		.res1       (res1)
	);

	// Advance the flags once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Output register count: load a fresh group, or shift the tail up on a pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (advance) begin
			out_cnt_q <= res_cnt;
		end else if (pop) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_head_q <= res0;
			out_tail_q <= res1;
		end else if (pop) begin
			out_head_q <= out_tail_q;
		end
	end

	assign token.valid        = (out_cnt_q != 2'd0);
	assign token.has_char     = out_head_q.has_char;
	assign token.char_out     = out_head_q.char_out;
	assign token.field_end    = out_head_q.field_end;
	assign token.line_end     = out_head_q.line_end;
	assign token.field_quoted = out_head_q.field_quoted;
	assign token.is_last      = out_head_q.is_last;

	// Two pending results are always a character followed by its end event
	`CFP_ASSERT_NOW(a_pair_head, out_cnt_q == 2'd2,
		out_head_q.has_char && !out_head_q.is_last && out_tail_q.field_end,
		"two-result group does not start with a payload character")
	// A single pending result closes its group
	`CFP_ASSERT_NOW(a_single_last, out_cnt_q == 2'd1, out_head_q.is_last,
		"last pending result is not marked last")
	// An item that cannot be decoded stays in the input register
	`CFP_ASSERT_NEXT(a_s1_hold, s1_v && !out_free, s1_v,
		"input register lost an item while the output register was busy")
	// After a CR line break the field flags are back at their start values
	`CFP_ASSERT_NOW(a_skip_clean, st_q.skip_lf,
		!st_q.started && !st_q.in_q && !st_q.q_pend && !st_q.was_q,
		"LF skip armed inside an open field")

endmodule

[rtl/cfp_step.sv]
// ----------------------------------------------------------------------------
// cfp_step
// Decode one code unit against the parser flags: next flags and up to two
// result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_step import cfp_pkg::*; (
	input  logic [CHAR_W-1:0] char_in,
	input  logic              stream_end,
	input  logic [CHAR_W-1:0] delimiter,
	input  state_t            st,
	output state_t            st_next,
	output logic [1:0]        res_cnt,
	output result_t           res0,
	output result_t           res1
);

	always_comb begin
		logic [CHAR_W-1:0] c;
		logic              done;
		logic              lb;
		logic              fin;
		logic              fin_line;
		logic              emit;
		result_t           rend;

		c        = char_in;
		done     = 1'b0;
		lb       = 1'b0;
		fin      = 1'b0;
		fin_line = 1'b0;
		emit     = 1'b0;
		rend     = '0;
		st_next  = st;
		st_next.skip_lf = 1'b0;
		res_cnt  = 2'd0;
		res0     = '0;
		res1     = '0;

		// Drop the LF of a CRLF pair
		if (st.skip_lf && c == CH_LF) begin
			done = 1'b1;
			if (stream_end) begin
				st_next.started = 1'b0;
				st_next.in_q    = 1'b0;
				st_next.q_pend  = 1'b0;
				st_next.was_q   = 1'b0;
			end
		end

		// Leading blanks and the opening quote
		if (!done && !st_next.started) begin
			if (c == CH_SPACE || c == CH_TAB) begin
				done     = 1'b1;
				fin      = stream_end;
				fin_line = 1'b1;
			end else begin
				st_next.started = 1'b1;
				if (c == CH_QUOTE) begin
					st_next.in_q  = 1'b1;
					st_next.was_q = 1'b1;
					done          = 1'b1;
					fin           = stream_end;
					fin_line      = 1'b1;
				end
			end
		end

		// Quote pairs inside quotes
		if (!done) begin
			if (c == CH_QUOTE) begin
				if (st_next.in_q) begin
					if (st_next.q_pend) begin
						st_next.q_pend = 1'b0;
					end else begin
						st_next.q_pend = 1'b1;
						done           = 1'b1;
						fin            = stream_end;
						fin_line       = 1'b1;
					end
				end
			end else if (st_next.q_pend) begin
				st_next.in_q   = 1'b0;
				st_next.q_pend = 1'b0;
			end
		end

		// Delimiter, line break or payload
		if (!done) begin
			if (!st_next.in_q) begin
				if (c == CH_CR) begin
					lb              = 1'b1;
					st_next.skip_lf = 1'b1;
					c               = CH_LF;
				end else if (c == CH_LF) begin
					lb = 1'b1;
				end
			end
			if (!st_next.in_q && c == delimiter) begin
				fin      = 1'b1;
				fin_line = stream_end;
			end else if (!st_next.in_q && lb) begin
				fin      = 1'b1;
				fin_line = 1'b1;
			end else begin
				emit     = 1'b1;
				fin      = stream_end;
				fin_line = 1'b1;
			end
		end

		if (emit) begin
			res0.has_char = 1'b1;
			res0.char_out = c;
		end

		if (fin) begin
			rend.field_end    = 1'b1;
			rend.line_end     = fin_line;
			rend.field_quoted = st_next.was_q;
			rend.is_last      = 1'b1;
			if (emit) begin
				res1    = rend;
				res_cnt = 2'd2;
			end else begin
				res0    = rend;
				res_cnt = 2'd1;
			end
			st_next.started = 1'b0;
			st_next.in_q    = 1'b0;
			st_next.q_pend  = 1'b0;
			st_next.was_q   = 1'b0;
			if (stream_end) begin
				st_next.skip_lf = 1'b0;
			end
		end else if (emit) begin
			res0.is_last = 1'b1;
			res_cnt      = 2'd1;
		end
	end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for csv_field_parser. A directed table runs first: the
// rows with an obvious outcome carry their tokens typed in, and the rest go to
// a bit-level model of the field splitter. Random CSV records follow under
// ten delimiter settings, with bursty text requests, a token side that stalls
// on its own pattern and one long token hold-off that backs the parser up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import cfp_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int PHASE_ITEMS   = 195;
	localparam int PHASES        = 10;
	localparam int DIRECTED_ROWS = 25;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AFTER    = 300;
	localparam int PRINT_CAP     = 40;

	localparam result_t NO_TOKEN = '0;

	// Delimiters of the random phases; the last phase draws its own.
	localparam logic [CHAR_W-1:0] PHASE_DELIMS [PHASES-1] = '{
		CH_COMMA, 16'hFFFF, 16'h0000, CH_CR, CH_LF, CH_SPACE, CH_TAB, CH_QUOTE, 16'h003B
	};

	// One text request plus, where the outcome is obvious, its typed tokens.
	typedef struct packed {
		logic [CHAR_W-1:0] cu;
		logic              eos;
		logic              typed;
		logic [1:0]        n_want;
		result_t           want0;
		result_t           want1;
	} text_row_t;

	logic clk;
	logic arst_n;
	logic delim_we;
	logic [CHAR_W-1:0] delim_wdata;

	cfp_text_if  text_ch ();
	cfp_token_if token_ch ();

	csv_field_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.token      (token_ch),
		.delim_we   (delim_we),
		.delim_wdata(delim_wdata)
	);

	// Parser model state: field flags and the delimiter as last written.
	state_t            flags     = '0;
	logic [CHAR_W-1:0] delim_cfg = CH_COMMA;

	result_t   step_tokens [$];
	result_t   tokens_due [$];
	text_row_t text_rows [$];
	text_row_t directed_rows [DIRECTED_ROWS];
	text_row_t cur_row = '0;

	int  mismatches  = 0;
	int  units_taken = 0;
	int  cycles      = 0;
	logic hold_token = 1'b0;

	// ------------------------------------------------------------------
	// Token and row builders
	// ------------------------------------------------------------------
	function automatic result_t tok_char(logic [CHAR_W-1:0] c, logic last);
		result_t t;
		t = '0;
		t.has_char = 1'b1;
		t.char_out = c;
		t.is_last  = last;
		return t;
	endfunction

	function automatic result_t tok_end(logic line, logic quoted);
		result_t t;
		t = '0;
		t.field_end    = 1'b1;
		t.line_end     = line;
		t.field_quoted = quoted;
		t.is_last      = 1'b1;
		return t;
	endfunction

	function automatic text_row_t row_free(logic [CHAR_W-1:0] cu, logic eos);
		text_row_t r;
		r = '0;
		r.cu  = cu;
		r.eos = eos;
		return r;
	endfunction

	function automatic text_row_t row_want(logic [CHAR_W-1:0] cu, logic eos,
		logic [1:0] n, result_t w0, result_t w1);
		text_row_t r;
		r = row_free(cu, eos);
		r.typed  = 1'b1;
		r.n_want = n;
		r.want0  = w0;
		r.want1  = w1;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Field splitter model: one code unit in, zero to two tokens out
	// ------------------------------------------------------------------
	function automatic void clear_field();
		flags.started = 1'b0;
		flags.in_q    = 1'b0;
		flags.q_pend  = 1'b0;
		flags.was_q   = 1'b0;
	endfunction

	// Close the field: emit the end token, then drop the field flags.
	function automatic void close_field(logic line, logic at_end);
		step_tokens.push_back(tok_end(line, flags.was_q));
		clear_field();
		if (at_end)
			flags.skip_lf = 1'b0;
	endfunction

	function automatic void split_unit(logic [CHAR_W-1:0] cu, logic eos);
		logic [CHAR_W-1:0] c;
		logic brk;
		c   = cu;
		brk = 1'b0;

		// An LF right after a line-ending CR vanishes, stream end or not.
		if (flags.skip_lf) begin
			flags.skip_lf = 1'b0;
			if (c == CH_LF) begin
				if (eos)
					clear_field();
				return;
			end
		end

		// Leading blanks and the opening quote come before any delimiter test.
		if (!flags.started) begin
			if (c == CH_SPACE || c == CH_TAB) begin
				if (eos)
					close_field(1'b1, 1'b1);
				return;
			end
			flags.started = 1'b1;
			if (c == CH_QUOTE) begin
				flags.in_q  = 1'b1;
				flags.was_q = 1'b1;
				if (eos)
					close_field(1'b1, 1'b1);
				return;
			end
		end

		// Inside quotes a quote is held back until the next unit decides.
		if (c == CH_QUOTE) begin
			if (flags.in_q) begin
				if (flags.q_pend) begin
					flags.q_pend = 1'b0;
				end else begin
					flags.q_pend = 1'b1;
					if (eos)
						close_field(1'b1, 1'b1);
					return;
				end
			end
		end else if (flags.q_pend) begin
			flags.in_q   = 1'b0;
			flags.q_pend = 1'b0;
		end

		// Unquoted CR folds to LF and arms the swallow of one LF.
		if (!flags.in_q) begin
			if (c == CH_CR) begin
				brk           = 1'b1;
				flags.skip_lf = 1'b1;
				c             = CH_LF;
			end else if (c == CH_LF) begin
				brk = 1'b1;
			end
		end

		if (!flags.in_q && c == delim_cfg) begin
			close_field(eos, eos);
			return;
		end
		if (!flags.in_q && brk) begin
			close_field(1'b1, eos);
			return;
		end
		step_tokens.push_back(tok_char(c, !eos));
		if (eos)
			close_field(1'b1, 1'b1);
	endfunction

	// ------------------------------------------------------------------
	// Random CSV text
	// ------------------------------------------------------------------
	function automatic logic [CHAR_W-1:0] pick_plain();
		case ($urandom_range(0, 9))
			0: return CHAR_W'($urandom_range(0, 65535));
			1: return delim_cfg;
			2: return CH_SPACE;
			default: return CHAR_W'($urandom_range(16'h0061, 16'h007A));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] pick_noise();
		case ($urandom_range(0, 7))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_QUOTE;
			3: return CH_SPACE;
			4: return CH_TAB;
			5: return delim_cfg;
			default: return CHAR_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void add_unit(logic [CHAR_W-1:0] cu, logic eos);
		text_rows.push_back(row_free(cu, eos));
	endfunction

	// Append one field with its terminator; a few records are pure noise.
	function automatic void add_record();
		int kind;
		kind = $urandom_range(0, 9);
		repeat ($urandom_range(0, 2))
			add_unit($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
		if (kind < 6) begin
			repeat ($urandom_range(0, 5))
				add_unit(pick_plain(), 1'b0);
		end else if (kind < 9) begin
			add_unit(CH_QUOTE, 1'b0);
			repeat ($urandom_range(0, 5)) begin
				case ($urandom_range(0, 5))
					0: begin
						add_unit(CH_QUOTE, 1'b0);
						add_unit(CH_QUOTE, 1'b0);
					end
					1: add_unit($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
					default: add_unit(pick_plain(), 1'b0);
				endcase
			end
			// Close the quote, now and then at stream end; sometimes stray text follows.
			if ($urandom_range(0, 7) == 0)
				add_unit(CH_QUOTE, $urandom_range(0, 3) == 0);
			else
				add_unit(CH_QUOTE, 1'b0);
			if ($urandom_range(0, 7) == 0)
				add_unit(pick_plain(), 1'b0);
		end else begin
			repeat ($urandom_range(1, 6))
				add_unit(pick_noise(), $urandom_range(0, 14) == 0);
		end
		case ($urandom_range(0, 19))
			11, 12, 13: begin
				add_unit(CH_CR, 1'b0);
				add_unit(CH_LF, 1'b0);
			end
			14: add_unit(CH_CR, 1'b0);
			15: add_unit(CH_LF, 1'b0);
			16: add_unit(delim_cfg, 1'b1);
			17: add_unit(CH_LF, 1'b1);
			18: add_unit(pick_plain(), 1'b1);
			19: begin
				add_unit(CH_CR, 1'b0);
				add_unit(CH_LF, 1'b1);
			end
			default: add_unit(delim_cfg, 1'b0);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic match_token(result_t got);
		result_t want;
		if (tokens_due.size() == 0) begin
			report_mismatch("token with nothing due", 32'(got), 32'd0);
			return;
		end
		want = tokens_due.pop_front();
		if (got.has_char != want.has_char)
			report_mismatch("has_char", 32'(got.has_char), 32'(want.has_char));
		if (got.char_out != want.char_out)
			report_mismatch("char_out", 32'(got.char_out), 32'(want.char_out));
		if (got.field_end != want.field_end)
			report_mismatch("field_end", 32'(got.field_end), 32'(want.field_end));
		if (got.line_end != want.line_end)
			report_mismatch("line_end", 32'(got.line_end), 32'(want.line_end));
		if (got.field_quoted != want.field_quoted)
			report_mismatch("field_quoted", 32'(got.field_quoted),
				32'(want.field_quoted));
		if (got.is_last != want.is_last)
			report_mismatch("is_last", 32'(got.is_last), 32'(want.is_last));
	endtask

	// Sample both channels on the rising edge. An accepted text request
	// advances the model; typed rows queue their own tokens instead.
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				units_taken++;
				step_tokens.delete();
				split_unit(text_ch.char_in, text_ch.stream_end);
				if (cur_row.typed) begin
					if (cur_row.n_want > 2'd0)
						tokens_due.push_back(cur_row.want0);
					if (cur_row.n_want > 2'd1)
						tokens_due.push_back(cur_row.want1);
				end else begin
					foreach (step_tokens[i])
						tokens_due.push_back(step_tokens[i]);
				end
			end
			if (token_ch.valid && token_ch.ready) begin
				got.has_char     = token_ch.has_char;
				got.char_out     = token_ch.char_out;
				got.field_end    = token_ch.field_end;
				got.line_end     = token_ch.line_end;
				got.field_quoted = token_ch.field_quoted;
				got.is_last      = token_ch.is_last;
				match_token(got);
			end
		end
	end

	// ------------------------------------------------------------------
	// Clock, watchdog, token side
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stop a hung run at a limit well past the slowest legal one.
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("[csv_field_parser] ERROR");
		$finish;
	end

	// Token side: switch between random stall patterns, or hold ready low on hold_token.
	initial begin
		int mode;
		int left;
		int tick;
		mode = 0;
		left = 0;
		tick = 0;
		token_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 96);
			end
			left--;
			tick++;
			if (hold_token)
				token_ch.ready <= 1'b0;
			else begin
				case (mode)
					0: token_ch.ready <= 1'b1;
					1: token_ch.ready <= ($urandom_range(0, 3) != 0);
					2: token_ch.ready <= ($urandom_range(0, 3) == 0);
					default: token_ch.ready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// Hold the token side off for a long stretch in mid-run while text keeps
	// coming, so the parser fills up and drops text ready.
	initial begin
		wait (units_taken >= HOLD_AFTER);
		@(posedge clk);
		hold_token = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_token = 1'b0;
	end

	// ------------------------------------------------------------------
	// Text side
	// ------------------------------------------------------------------

	// Drive the queued rows in bursts; hold each request until it is taken.
	task automatic send_rows();
		int burst;
		int gap;
		burst = 0;
		@(negedge clk);
		while (text_rows.size() != 0) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					text_ch.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst--;
			cur_row = text_rows.pop_front();
			text_ch.valid      <= 1'b1;
			text_ch.char_in    <= cur_row.cu;
			text_ch.stream_end <= cur_row.eos;
			do
				@(posedge clk);
			while (!text_ch.ready);
			@(negedge clk);
		end
		text_ch.valid <= 1'b0;
	endtask

	// Wait out every due token, then settle for requests that make none.
	task automatic wait_drained();
		while (tokens_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_delimiter(logic [CHAR_W-1:0] d);
		@(negedge clk);
		delim_we    <= 1'b1;
		delim_wdata <= d;
		@(negedge clk);
		delim_we    <= 1'b0;
		delim_cfg = d;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [CHAR_W-1:0] d;
		arst_n             <= 1'b0;
		delim_we           <= 1'b0;
		delim_wdata        <= '0;
		text_ch.valid      <= 1'b0;
		text_ch.char_in    <= '0;
		text_ch.stream_end <= 1'b0;

		directed_rows = '{
			// After reset: a letter is payload, comma closes its field.
			row_want(16'h0061, 1'b0, 2'd1, tok_char(16'h0061, 1'b1), NO_TOKEN),
			row_want(CH_COMMA, 1'b0, 2'd1, tok_end(1'b0, 1'b0), NO_TOKEN),
			// Leading blanks drop, then a quote opens the field.
			row_want(CH_SPACE, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN),
			row_want(CH_TAB, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN),
			row_want(CH_QUOTE, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN),
			// Doubled quote gives one literal quote.
			row_want(CH_QUOTE, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN),
			row_want(CH_QUOTE, 1'b0, 2'd1, tok_char(CH_QUOTE, 1'b1), NO_TOKEN),
			// CR and LF inside quotes pass through as payload.
			row_free(CH_CR, 1'b0),
			row_free(CH_LF, 1'b0),
			// Closing quote, then CR ends the quoted line; the LF vanishes.
			row_free(CH_QUOTE, 1'b0),
			row_want(CH_CR, 1'b0, 2'd1, tok_end(1'b1, 1'b1), NO_TOKEN),
			row_want(CH_LF, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN),
			// Code unit extremes, then a bare LF ends the line.
			row_want(16'hFFFF, 1'b0, 2'd1, tok_char(16'hFFFF, 1'b1), NO_TOKEN),
			row_want(16'h0000, 1'b0, 2'd1, tok_char(16'h0000, 1'b1), NO_TOKEN),
			row_want(CH_LF, 1'b0, 2'd1, tok_end(1'b1, 1'b0), NO_TOKEN),
			// Stream end: empty quoted field, payload then end, delimiter.
			row_want(CH_QUOTE, 1'b1, 2'd1, tok_end(1'b1, 1'b1), NO_TOKEN),
			row_want(16'h0078, 1'b1, 2'd2, tok_char(16'h0078, 1'b0), tok_end(1'b1, 1'b0)),
			row_want(CH_COMMA, 1'b1, 2'd1, tok_end(1'b1, 1'b0), NO_TOKEN),
			// Swallowed LF carrying stream end, then a blank at stream end.
			row_free(CH_CR, 1'b0),
			row_want(CH_LF, 1'b1, 2'd0, NO_TOKEN, NO_TOKEN),
			row_want(CH_SPACE, 1'b1, 2'd1, tok_end(1'b1, 1'b0), NO_TOKEN),
			// Quote closed by a plain unit, which lands at stream end.
			row_free(CH_QUOTE, 1'b0),
			row_free(16'h0062, 1'b0),
			row_free(CH_QUOTE, 1'b0),
			row_free(16'h0063, 1'b1)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			text_rows.push_back(directed_rows[i]);
		send_rows();
		wait_drained();

		// Random phases, one delimiter each; rewrite only while idle.
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				d = CHAR_W'($urandom_range(0, 65535));
			else
				d = PHASE_DELIMS[p];
			set_delimiter(d);
			while (text_rows.size() < PHASE_ITEMS)
				add_record();
			send_rows();
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[csv_field_parser] OK");
		else
			$display("[csv_field_parser] ERROR");
		$finish;
	end

endmodule

[csv_field_parser.f]
+incdir+rtl
rtl/cfp_pkg.sv
rtl/cfp_text_if.sv
rtl/cfp_token_if.sv
rtl/cfp_step.sv
rtl/csv_field_parser.sv
bench/testbench.sv
